// ----- src/u2c_pkg.sv -----
`timescale 1ns / 1ps

package u2c_pkg;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       in_last;
   } u2c_req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       has_byte;
      logic       bad_char;
      logic       out_last;
   } u2c_rsp_type;

   typedef struct packed {
      logic [1:0]  count;
      u2c_rsp_type r0;
      u2c_rsp_type r1;
   } u2c_push_type;

   typedef struct packed {
      logic       ok;
      logic       two;
      logic [7:0] b0;
      logic [7:0] b1;
   } u2c_emit_type;

   localparam int unsigned CODE_W = 21;

   localparam logic [7:0] ZERO_CODE  = 8'hE0;
   localparam logic [7:0] PAIR_ESC   = 8'hE1;
   localparam logic [7:0] HI_OFFSET  = 8'h40;
   localparam logic [7:0] CONT_MASK  = 8'hC0;
   localparam logic [7:0] CONT_TAG   = 8'h80;
   localparam logic [7:0] LEAD2_MASK = 8'hE0;
   localparam logic [7:0] LEAD2_TAG  = 8'hC0;
   localparam logic [7:0] LEAD3_MASK = 8'hF0;
   localparam logic [7:0] LEAD3_TAG  = 8'hE0;
   localparam logic [7:0] LEAD4_MASK = 8'hF8;
   localparam logic [7:0] LEAD4_TAG  = 8'hF0;
   localparam logic [7:0] PAYLOAD_MASK = 8'h3F;

   localparam logic [CODE_W-1:0] ASCII_END = 21'h00080;
   localparam logic [CODE_W-1:0] CJK_LOW   = 21'h04000;
   localparam logic [CODE_W-1:0] CJK_END   = 21'h0A000;

   function automatic u2c_emit_type emit_code(input logic [CODE_W-1:0] u);
      u2c_emit_type e;
      logic [7:0]   hi;
      logic [7:0]   lo;
      hi = u[15:8] + HI_OFFSET;
      lo = u[7:0];
      e  = '0;
      if (u < ASCII_END) begin
         e.ok = 1'b1;
         e.b0 = (u[6:0] == 7'd0) ? ZERO_CODE : {1'b0, u[6:0]};
      end else if (u >= CJK_LOW && u < CJK_END) begin
         e.ok  = 1'b1;
         e.two = 1'b1;
         if (lo == 8'd0) begin
            e.b0 = PAIR_ESC;
            e.b1 = hi;
         end else begin
            e.b0 = hi;
            e.b1 = lo;
         end
      end
      return e;
   endfunction

endpackage

// ----- src/u2c_if.sv -----
`timescale 1ns / 1ps

interface u2c_req_if;
   import u2c_pkg::*;
   logic        valid;
   logic        ready;
   u2c_req_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

interface u2c_rsp_if;
   import u2c_pkg::*;
   logic        valid;
   logic        ready;
   u2c_rsp_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

// ----- src/u2c_decode.sv -----
`timescale 1ns / 1ps

module u2c_decode (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   item_valid,
   input  u2c_pkg::u2c_req_type   item,
   output u2c_pkg::u2c_push_type  push
);
   import u2c_pkg::*;

   logic [1:0]        pending_ff, pending_in;
   logic [CODE_W-1:0] accum_ff, accum_in;
   logic              dropping_ff, dropping_in;

   logic [7:0]        b;
   logic              last;
   logic [CODE_W-1:0] shifted;
   u2c_emit_type      e;
   logic              err;
   logic              emit_en;
   logic [1:0]        n;
   u2c_rsp_type       r0, r1;

   assign b       = item.in_byte;
   assign last    = item.in_last;
   assign shifted = {accum_ff[CODE_W-7:0], b[5:0] & PAYLOAD_MASK[5:0]};

   always_comb begin
      pending_in  = pending_ff;
      accum_in    = accum_ff;
      dropping_in = dropping_ff;
      err         = 1'b0;
      emit_en     = 1'b0;
      e           = emit_code(pending_ff == 2'd0 ? CODE_W'(b) : shifted);
      n           = 2'd0;
      r0          = '0;
      r1          = '0;

      if (dropping_ff) begin
         if (last) begin
            dropping_in = 1'b0;
            pending_in  = 2'd0;
            accum_in    = '0;
         end
      end else begin
         if (pending_ff == 2'd0) begin
            if (!b[7]) begin
               emit_en = 1'b1;
            end else if ((b & CONT_MASK) == CONT_TAG) begin
               emit_en = 1'b0;
            end else if ((b & LEAD2_MASK) == LEAD2_TAG) begin
               pending_in = 2'd1;
               accum_in   = CODE_W'(b[4:0]);
            end else if ((b & LEAD3_MASK) == LEAD3_TAG) begin
               pending_in = 2'd2;
               accum_in   = CODE_W'(b[3:0]);
            end else if ((b & LEAD4_MASK) == LEAD4_TAG) begin
               pending_in = 2'd3;
               accum_in   = CODE_W'(b[2:0]);
            end else begin
               err = 1'b1;
            end
         end else if ((b & CONT_MASK) == CONT_TAG) begin
            accum_in   = shifted;
            pending_in = pending_ff - 2'd1;
            if (pending_ff == 2'd1) begin
               emit_en  = 1'b1;
               accum_in = '0;
            end
         end else begin
            err = 1'b1;
         end

         if (emit_en) begin
            if (e.ok) begin
               n           = e.two ? 2'd2 : 2'd1;
               r0.out_byte = e.b0;
               r0.has_byte = 1'b1;
               r1.out_byte = e.b1;
               r1.has_byte = 1'b1;
            end else begin
               err = 1'b1;
            end
         end

         if (!err && last && pending_in != 2'd0) begin
            err = 1'b1;
         end

         if (err) begin
            n           = 2'd1;
            r0          = '0;
            r0.bad_char = 1'b1;
            r0.out_last = 1'b1;
            r1          = '0;
            pending_in  = 2'd0;
            accum_in    = '0;
            dropping_in = !last;
         end else if (last) begin
            pending_in = 2'd0;
            accum_in   = '0;
            if (n == 2'd0) begin
               n  = 2'd1;
               r0 = '0;
            end
            if (n == 2'd2) begin
               r1.out_last = 1'b1;
            end else begin
               r0.out_last = 1'b1;
            end
         end
      end
   end

   always_comb begin
      push.count = item_valid ? n : 2'd0;
      push.r0    = r0;
      push.r1    = r1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff  <= 2'd0;
         accum_ff    <= '0;
         dropping_ff <= 1'b0;
      end else if (item_valid) begin
         pending_ff  <= pending_in;
         accum_ff    <= accum_in;
         dropping_ff <= dropping_in;
      end
   end

   a_drop_silent: assert property (@(posedge clock) disable iff (reset)
      dropping_ff |-> push.count == 2'd0)
      else $error("results produced while dropping");

   a_bad_is_last: assert property (@(posedge clock) disable iff (reset)
      (push.count != 2'd0 && push.r0.bad_char) |-> (push.r0.out_last && push.count == 2'd1))
      else $error("error result not final");

   a_drop_clean: assert property (@(posedge clock) disable iff (reset)
      dropping_ff |-> (pending_ff == 2'd0 && accum_ff == '0))
      else $error("sequence state left open while dropping");

endmodule

// ----- src/u2c_rsp_fifo.sv -----
`timescale 1ns / 1ps

module u2c_rsp_fifo #(
   parameter int unsigned DEPTH = 4
) (
   input  logic                  clock,
   input  logic                  reset,
   input  u2c_pkg::u2c_push_type push,
   output logic                  room,
   u2c_rsp_if.source             rsp_ch
);
   import u2c_pkg::*;

   localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CW = $clog2(DEPTH + 1);

   u2c_rsp_type       entries_ff [DEPTH];
   logic [PW-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]     count_ff, count_in;
   logic [PW-1:0]     wr_next;
   logic              pop;

   function automatic logic [PW-1:0] next_ptr(input logic [PW-1:0] p);
      return (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
   endfunction

   assign wr_next = next_ptr(wr_ptr_ff);
   assign pop     = (count_ff != '0) && rsp_ch.ready;
   assign room    = count_ff <= CW'(DEPTH - 2);

   assign rsp_ch.valid = count_ff != '0;
   assign rsp_ch.data  = entries_ff[rd_ptr_ff];

   always_comb begin
      unique case (push.count)
         2'd1:    wr_ptr_in = wr_next;
         2'd2:    wr_ptr_in = next_ptr(wr_next);
         default: wr_ptr_in = wr_ptr_ff;
      endcase
      rd_ptr_in = pop ? next_ptr(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff + CW'(push.count) - CW'(pop);
   end

   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         entries_ff[wr_ptr_ff] <= push.r0;
      end
      if (push.count == 2'd2) begin
         entries_ff[wr_next] <= push.r1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(DEPTH))
      else $error("response queue overflow");

   a_push_fits: assert property (@(posedge clock) disable iff (reset)
      push.count != 2'd0 |-> room)
      else $error("push without room");

   a_count_track: assert property (@(posedge clock) disable iff (reset)
      (push.count == 2'd0 && !pop) |=> $stable(count_ff))
      else $error("queue count moved without transaction");

endmodule

// ----- src/utf8_to_compact_cjk_code_core.sv -----
`timescale 1ns / 1ps
// UTF-8 to compact CJK code converter.
// req_ch carries one UTF-8 byte per transaction plus a flag for the final byte
// of a string. rsp_ch returns the compact code one byte per transaction; each
// request yields zero, one or two responses, and the last response of a string
// has out_last set (an error response or a bare end marker may stand alone).
// Path: a request accepted on req_ch is held in the input register, decoded
// and written into the response queue once the queue has room, and its first
// response is offered from the queue on rsp_ch.
// Throughput: one request per cycle while responses are taken each cycle;
// requests that expand to two responses take two rsp_ch transactions.
// The request register moves on when the queue has room for two responses.
// When the receiver stalls, the queue (RSP_DEPTH entries) fills and req_ch.ready
// falls once the input register holds a request that cannot be placed.
// Synchronous reset empties the queue and input register and returns the
// decoder to the start of a new string.
module utf8_to_compact_cjk_code_core #(
   parameter int unsigned RSP_DEPTH = 4
) (
   input  logic       clock,
   input  logic       reset,
   u2c_req_if.sink    req_ch,
   u2c_rsp_if.source  rsp_ch
);
   import u2c_pkg::*;

   logic         hold_valid_ff, hold_valid_in;
   u2c_req_type  hold_data_ff;
   logic         room;
   logic         advance;
   logic         req_take;
   u2c_push_type push;

   assign advance      = hold_valid_ff && room;
   assign req_ch.ready = !hold_valid_ff || advance;
   assign req_take     = req_ch.valid && req_ch.ready;

   always_comb begin
      hold_valid_in = hold_valid_ff;
      if (req_take) begin
         hold_valid_in = 1'b1;
      end else if (advance) begin
         hold_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_valid_ff <= 1'b0;
      end else begin
         hold_valid_ff <= hold_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         hold_data_ff <= req_ch.data;
      end
   end

   u2c_decode u_decode (
      .clock      (clock),
      .reset      (reset),
      .item_valid (advance),
      .item       (hold_data_ff),
      .push       (push)
   );

   u2c_rsp_fifo #(
      .DEPTH (RSP_DEPTH)
   ) u_rsp_fifo (
      .clock  (clock),
      .reset  (reset),
      .push   (push),
      .room   (room),
      .rsp_ch (rsp_ch)
   );

   a_hold_stall: assert property (@(posedge clock) disable iff (reset)
      (hold_valid_ff && !room) |=> (hold_valid_ff && $stable(hold_data_ff)))
      else $error("held request lost while queue full");

   a_ready_rule: assert property (@(posedge clock) disable iff (reset)
      req_ch.ready == (!hold_valid_ff || room))
      else $error("request ready inconsistent with queue room");

   a_push_needs_item: assert property (@(posedge clock) disable iff (reset)
      !hold_valid_ff |-> push.count == 2'd0)
      else $error("responses pushed with no request held");

endmodule
